FILE: rtl/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

  // Line store geometry follows from the widest source row.
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int LineDepth = MaxWidth / 2;
  localparam int SlotW     = $clog2(LineDepth);

  // Field widths.
  localparam int ChanW  = 8;
  localparam int PairW  = ChanW + 1;
  localparam int LineW  = 3 * PairW;
  localparam int SizeW  = 13;
  localparam int CountW = 12;
  localparam int CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSourceWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSourceHeight = 1'b1;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [SlotW-1:0] slot_t;
  typedef logic [LineW-1:0] line_word_t;

  // One line store operation, issued on an accepted beat.
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       last;
    slot_t      slot;
    line_word_t pair;
  } line_op_t;

  // Out-of-range sizes act as the nearest legal size.
  function automatic size_t clamp_size(input size_t v, input int hi);
    size_t r;
    if (v < size_t'(2)) begin
      r = size_t'(2);
    end else if (int'(v) > hi) begin
      r = size_t'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/rbd_if.sv
`timescale 1ns / 1ps

// Source pixel channel.
interface rbd_pixel_if;
  logic               valid;
  logic               ready;
  rbd_pkg::chan_t     in_red;
  rbd_pkg::chan_t     in_green;
  rbd_pkg::chan_t     in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

// Downsampled pixel channel.
interface rbd_result_if;
  logic               valid;
  logic               ready;
  rbd_pkg::chan_t     out_red;
  rbd_pkg::chan_t     out_green;
  rbd_pkg::chan_t     out_blue;
  logic               frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

FILE: rtl/rbd_line_ram.sv
`timescale 1ns / 1ps

// Single-port line store with a registered read.
module rbd_line_ram (
  input  logic                clk,
  input  logic                we,
  input  logic                re,
  input  rbd_pkg::slot_t      addr,
  input  rbd_pkg::line_word_t wdata,
  output rbd_pkg::line_word_t rdata
);

  rbd_pkg::line_word_t mem [rbd_pkg::LineDepth];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/rbd_raster_ctrl.sv
`timescale 1ns / 1ps

// Raster position tracking, left-pixel hold and pair sums.
module rbd_raster_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rbd_pkg::CfgIdxW-1:0]   cfg_index,
  input  rbd_pkg::size_t                cfg_data,
  input  logic                          room,
  rbd_pixel_if.sink                     pixel,
  output rbd_pkg::line_op_t             op
);

  rbd_pkg::size_t  width;
  rbd_pkg::size_t  height;
  rbd_pkg::count_t column_count;
  rbd_pkg::count_t row_count;
  rbd_pkg::chan_t  hold_red;
  rbd_pkg::chan_t  hold_green;
  rbd_pkg::chan_t  hold_blue;

  logic            accept;
  rbd_pkg::size_t  w_even;
  rbd_pkg::size_t  h_even;
  rbd_pkg::size_t  col_ext;
  rbd_pkg::size_t  row_ext;
  rbd_pkg::size_t  col_inc;
  rbd_pkg::size_t  row_inc;
  logic            pair_col;
  logic [rbd_pkg::PairW-1:0] sum_red;
  logic [rbd_pkg::PairW-1:0] sum_green;
  logic [rbd_pkg::PairW-1:0] sum_blue;

  assign pixel.ready = room;
  assign accept      = pixel.valid && room;

  // Size registers are stored already clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= rbd_pkg::size_t'(rbd_pkg::MaxWidth);
      height <= rbd_pkg::size_t'(rbd_pkg::MaxHeight);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbd_pkg::CfgSourceWidth: begin
          width <= rbd_pkg::clamp_size(cfg_data, rbd_pkg::MaxWidth);
        end
        rbd_pkg::CfgSourceHeight: begin
          height <= rbd_pkg::clamp_size(cfg_data, rbd_pkg::MaxHeight);
        end
        default: begin
        end
      endcase
    end
  end

  assign w_even  = {width[rbd_pkg::SizeW-1:1], 1'b0};
  assign h_even  = {height[rbd_pkg::SizeW-1:1], 1'b0};
  assign col_ext = rbd_pkg::size_t'(column_count);
  assign row_ext = rbd_pkg::size_t'(row_count);
  assign col_inc = col_ext + rbd_pkg::size_t'(1);
  assign row_inc = row_ext + rbd_pkg::size_t'(1);

  // Odd column that closes a complete horizontal pair.
  assign pair_col = column_count[0] && (col_ext < w_even);

  assign sum_red   = {1'b0, hold_red} + {1'b0, pixel.in_red};
  assign sum_green = {1'b0, hold_green} + {1'b0, pixel.in_green};
  assign sum_blue  = {1'b0, hold_blue} + {1'b0, pixel.in_blue};

  // Even rows store the pair sum, odd rows fetch the stored one.
  always_comb begin
    op.wr   = accept && pair_col && !row_count[0];
    op.rd   = accept && pair_col && row_count[0] && (row_ext < h_even);
    op.last = (row_ext == h_even - rbd_pkg::size_t'(1)) &&
              (col_ext == w_even - rbd_pkg::size_t'(1));
    op.slot = rbd_pkg::slot_t'(column_count >> 1);
    op.pair = {sum_blue, sum_green, sum_red};
  end

  // Counters wrap at the configured frame size.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_inc >= width) begin
        column_count <= '0;
        if (row_inc >= height) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[rbd_pkg::CountW-1:0];
        end
      end else begin
        column_count <= col_inc[rbd_pkg::CountW-1:0];
      end
    end
  end

  // Even-column pixel waits here for its right neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_red   <= '0;
      hold_green <= '0;
      hold_blue  <= '0;
    end else if (accept && !column_count[0]) begin
      hold_red   <= pixel.in_red;
      hold_green <= pixel.in_green;
      hold_blue  <= pixel.in_blue;
    end
  end

  a_one_line_access: assert property (@(posedge clk) disable iff (rst)
    !(op.wr && op.rd))
    else $error("line store read and write in the same beat");

  a_last_is_result: assert property (@(posedge clk) disable iff (rst)
    (accept && pair_col && row_count[0] && op.last) |-> op.rd)
    else $error("frame end beat produced no read");

  a_counts_in_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && $stable(width) && $stable(height) && col_ext < width) |=>
      (col_ext < width))
    else $error("column count escaped the row");

endmodule

FILE: rtl/rbd_avg_stage.sv
`timescale 1ns / 1ps

// Combines the fetched pair sums with the current ones and holds the result.
module rbd_avg_stage (
  input  logic                clk,
  input  logic                rst,
  input  rbd_pkg::line_op_t   op,
  input  rbd_pkg::line_word_t rd_data,
  output logic                room,
  rbd_result_if.source        result
);

  logic                s1_valid;
  rbd_pkg::line_word_t s1_pair;
  logic                s1_last;
  logic                advance;
  logic [rbd_pkg::PairW+1:0] tot_red;
  logic [rbd_pkg::PairW+1:0] tot_green;
  logic [rbd_pkg::PairW+1:0] tot_blue;

  localparam int Pw = rbd_pkg::PairW;

  assign advance = !result.valid || result.ready;
  assign room    = !s1_valid || advance;

  // Stage one waits for the line store read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (op.rd) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.rd) begin
      s1_pair <= op.pair;
      s1_last <= op.last;
    end
  end

  // Four-pixel sums with rounding.
  always_comb begin
    tot_red   = (Pw+2)'(rd_data[Pw-1:0]) + (Pw+2)'(s1_pair[Pw-1:0]) + (Pw+2)'(2);
    tot_green = (Pw+2)'(rd_data[2*Pw-1:Pw]) + (Pw+2)'(s1_pair[2*Pw-1:Pw]) + (Pw+2)'(2);
    tot_blue  = (Pw+2)'(rd_data[3*Pw-1:2*Pw]) + (Pw+2)'(s1_pair[3*Pw-1:2*Pw]) + (Pw+2)'(2);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result.out_red    <= tot_red[rbd_pkg::ChanW+1:2];
      result.out_green  <= tot_green[rbd_pkg::ChanW+1:2];
      result.out_blue   <= tot_blue[rbd_pkg::ChanW+1:2];
      result.frame_last <= s1_last;
    end
  end

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    op.rd |=> s1_valid)
    else $error("line store read lost");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_pair) && $stable(s1_last)))
    else $error("stalled stage one changed");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    op.rd |-> room)
    else $error("read issued without room");

endmodule

FILE: rtl/rgb_box_downsample_2x2.sv
`timescale 1ns / 1ps

// 2x2 box-filter downsampler: takes one RGB pixel per clock in raster order and
// returns a pixel of (sum + 2) / 4 per channel for each 2x2 block, flagging
// the last one of the frame with frame_last. An odd last column or row is
// consumed without output. Each accepted pixel makes at most one access to the
// single-port line store of pair sums, so the block sustains one pixel per cycle
// unless the output stalls; each result passes stage one and the output register.
// Set source_width and source_height (2 to 4096) only between frames.
module rgb_box_downsample_2x2 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rbd_pkg::CfgIdxW-1:0] cfg_index,
  input  rbd_pkg::size_t              cfg_data,
  rbd_pixel_if.sink                   pixel,
  rbd_result_if.source                result
);

  rbd_pkg::line_op_t   op;
  rbd_pkg::line_word_t rd_data;
  logic                room;

  // Raster position, hold register and pair sums.
  rbd_raster_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .room      (room),
    .pixel     (pixel),
    .op        (op)
  );

  // Pair sums of the even row.
  rbd_line_ram u_line (
    .clk   (clk),
    .we    (op.wr),
    .re    (op.rd),
    .addr  (op.slot),
    .wdata (op.pair),
    .rdata (rd_data)
  );

  // Block average and output register.
  rbd_avg_stage u_avg (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .rd_data (rd_data),
    .room    (room),
    .result  (result)
  );

endmodule
